FILE: hdl/scbd_pkg.sv
// Shared types, codes and address map constants for the sound-CPU bus decoder.
// Used by every module of the decoder; depends on nothing.
package scbd_pkg;

    // target codes
    localparam logic [2:0] TGT_RAM  = 3'd0;
    localparam logic [2:0] TGT_FM   = 3'd1;
    localparam logic [2:0] TGT_BANK = 3'd2;
    localparam logic [2:0] TGT_EXT  = 3'd3;
    localparam logic [2:0] TGT_NONE = 3'd4;

    // fm chip operations
    localparam logic [1:0] FM_STATUS = 2'd0;
    localparam logic [1:0] FM_ADDR0  = 2'd1;
    localparam logic [1:0] FM_DATA   = 2'd2;
    localparam logic [1:0] FM_ADDR1  = 2'd3;

    // forced read data codes
    localparam logic [1:0] FORCE_NONE = 2'd0;
    localparam logic [1:0] FORCE_00   = 2'd1;
    localparam logic [1:0] FORCE_FF   = 2'd2;

    // access kind
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // sound cpu address map
    localparam logic [15:0] RAM_LAST   = 16'h3FFF;
    localparam logic [15:0] FM_LAST    = 16'h5FFF;
    localparam logic [15:0] BANK_LAST  = 16'h60FF;
    localparam logic [15:0] VDP_FIRST  = 16'h7F00;
    localparam logic [15:0] VDP_LAST   = 16'h7FFF;
    localparam logic [15:0] WIN_FIRST  = 16'h8000;

    // main bus map
    localparam logic [15:0] VDP_BASE_HI = 16'hC000;
    localparam logic [23:0] LOW_LAST    = 24'h9FFFFF;
    localparam logic [23:0] IO_FIRST    = 24'hA10000;
    localparam logic [23:0] IO_LAST     = 24'hA1FFFF;
    localparam logic [23:0] VDP_MFIRST  = 24'hC00000;
    localparam logic [23:0] VDP_MLAST   = 24'hC000FF;
    localparam logic [23:0] WRAM_FIRST  = 24'hE00000;

    localparam int BANK_W = 9;

    // one bus access
    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } scbd_access_t;

    // one decoded result
    typedef struct packed {
        logic [2:0]        target;
        logic [12:0]       ram_address;
        logic [1:0]        fm_operation;
        logic [23:0]       external_address;
        logic              external_permitted;
        logic              upper_lane;
        logic [15:0]       bus_word_data;
        logic [1:0]        forced_read;
        logic [BANK_W-1:0] bank_value;
    } scbd_result_t;

endpackage

FILE: hdl/sound_cpu_bus_decoder_banked_core.sv
// Top level of the sound-CPU bus decoder: input stage, decode and result register.
// Depends on scbd_pkg, scbd_in_stage and scbd_decode.
//
//  channel | dir | tuser         | tdata
//  s_      | in  | cmd           | address, write_data
//  m_      | out | target        | ram_address .. bank_value
//
// One beat per cycle sustained while m_tready stays high; a beat passes through
// the input register and then the result register on its way from input to result.
// aresetn is synchronous and active low; it empties both registers and clears the bank.
// A stall on m_tready holds the result and backs up into s_tready in the same cycle once the input register is full.
module sound_cpu_bus_decoder_banked_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // cmd
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // target
    output logic [71:0] m_tdata    // ram_address[12:0], fm_operation[14:13],
                                   // external_address[38:15], external_permitted[39],
                                   // upper_lane[40], bus_word_data[56:41],
                                   // forced_read[58:57], bank_value[67:59], zero[71:68]
);
    import scbd_pkg::*;

    logic         advance;
    logic         item_valid;
    scbd_access_t item;
    scbd_result_t result;
    scbd_result_t res_reg;
    logic         m_valid_reg, m_valid_next;

    assign advance = !m_valid_reg || m_tready;

    scbd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    scbd_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (item_valid && advance),
        .item    (item),
        .result  (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = item_valid;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.target;
    assign m_tdata  = {4'b0000,
                       res_reg.bank_value,
                       res_reg.forced_read,
                       res_reg.bus_word_data,
                       res_reg.upper_lane,
                       res_reg.external_permitted,
                       res_reg.external_address,
                       res_reg.fm_operation,
                       res_reg.ram_address};

endmodule

FILE: hdl/scbd_in_stage.sv
// Input register of the bus decoder: takes one access beat into a holding register.
// Depends on scbd_pkg.
module scbd_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,       // cmd
    input  logic [23:0]           s_tdata,       // address[15:0], write_data[23:16]
    input  logic                  advance,
    output logic                  item_valid,
    output scbd_pkg::scbd_access_t item
);
    import scbd_pkg::*;

    logic         valid_reg, valid_next;
    scbd_access_t item_reg;

    // free when empty or when the held beat moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd        <= s_tuser;
            item_reg.address    <= s_tdata[15:0];
            item_reg.write_data <= s_tdata[23:16];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/scbd_decode.sv
// Address decode and bank register of the bus decoder.
// Depends on scbd_pkg; the bank register shifts when a bank write is committed.
module scbd_decode (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   commit,
    input  scbd_pkg::scbd_access_t item,
    output scbd_pkg::scbd_result_t result
);
    import scbd_pkg::*;

    logic [BANK_W-1:0] bank_reg, bank_next;
    logic              wr;
    logic              is_ext;
    logic              allowed;
    logic [23:0]       ext_addr;
    logic [15:0]       a;

    assign wr = (item.cmd == CMD_WRITE);
    assign a  = item.address;

    // region decode
    always_comb begin
        result                    = '0;
        result.target             = TGT_NONE;
        bank_next                 = bank_reg;
        is_ext                    = 1'b0;
        ext_addr                  = '0;
        if (a <= RAM_LAST) begin
            result.target      = TGT_RAM;
            result.ram_address = a[12:0];
        end else if (a <= FM_LAST) begin
            result.target = TGT_FM;
            if (wr) begin
                case (a[1:0])
                    2'd0:    result.fm_operation = FM_ADDR0;
                    2'd2:    result.fm_operation = FM_ADDR1;
                    default: result.fm_operation = FM_DATA;
                endcase
            end else begin
                result.fm_operation = FM_STATUS;
            end
        end else if (a <= BANK_LAST && wr) begin
            result.target = TGT_BANK;
            bank_next     = {item.write_data[0], bank_reg[BANK_W-1:1]};
        end else if (a >= VDP_FIRST && a <= VDP_LAST) begin
            is_ext   = 1'b1;
            ext_addr = {VDP_BASE_HI, a[7:0]};
        end else if (a >= WIN_FIRST) begin
            is_ext   = 1'b1;
            ext_addr = 24'({bank_reg, a[14:0]});
        end

        // main bus range check
        allowed = (ext_addr <= LOW_LAST)
               || (ext_addr >= IO_FIRST && ext_addr <= IO_LAST)
               || (ext_addr >= VDP_MFIRST && ext_addr <= VDP_MLAST)
               || (wr && ext_addr >= WRAM_FIRST);

        if (is_ext) begin
            result.target             = TGT_EXT;
            result.external_address   = ext_addr;
            result.external_permitted = allowed;
            result.upper_lane         = !ext_addr[0];
            if (wr) begin
                result.bus_word_data = {item.write_data, item.write_data};
            end else if (!allowed) begin
                result.forced_read = FORCE_FF;
            end
        end else if (result.target == TGT_NONE && !wr) begin
            result.forced_read = FORCE_00;
        end

        result.bank_value = bank_next;
    end

    // bank register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg <= '0;
        end else if (commit) begin
            bank_reg <= bank_next;
        end
    end

endmodule
